/* rtl/core/lcdcf_pkg.sv */
// Shared types, constants and helper functions of the cell frame buffer packetizer.
`default_nettype none
package lcdcf_pkg;

    // Pixel store: one byte holds 8 vertically adjacent pixels of one column.
    localparam int FB_WIDTH  = 8;
    localparam int FB_DEPTH  = 768;
    localparam int FB_AW     = 10;
    // Dirty map: one word per cell column, one bit per cell row.
    localparam int DM_WIDTH  = 4;
    localparam int DM_DEPTH  = 12;
    localparam int DM_AW     = 4;
    localparam logic [DM_AW-1:0] DM_LAST = 4'd11;
    localparam logic [6:0] X_MAX = 7'd95;

    // Input actions.
    localparam logic [2:0] ACT_WRITE     = 3'd0;
    localparam logic [2:0] ACT_READ      = 3'd1;
    localparam logic [2:0] ACT_REDRAW    = 3'd2;
    localparam logic [2:0] ACT_BACKLIGHT = 3'd3;
    localparam logic [2:0] ACT_INIT      = 3'd4;

    // Result kinds.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Emit requests from the sequencer to the packet stage.
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_CELL1 = 3'd1;
    localparam logic [2:0] OP_CELL2 = 3'd2;
    localparam logic [2:0] OP_BL    = 3'd3;
    localparam logic [2:0] OP_INIT  = 3'd4;

    // Command constants.
    localparam logic [3:0]  TAG_CELL1 = 4'hd;
    localparam logic [3:0]  TAG_CELL2 = 4'ha;
    localparam logic [3:0]  TAG_BL    = 4'h0;
    localparam logic [7:0]  BL_ON     = 8'h95;
    localparam logic [7:0]  BL_OFF    = 8'h96;
    localparam logic [7:0]  INIT_B2   = 8'h86;
    localparam logic [7:0]  INIT_B3   = 8'h51;
    localparam logic [7:0]  INIT_TAG  = 8'h01;
    localparam logic [39:0] INIT_PAY  = 40'hea_ee_0a_19_28;
    localparam logic [4:0]  TAG_MOD   = 5'd10;

    typedef struct packed {
        logic        go;
        logic [2:0]  op;
        logic        rbit;
        logic        on;
        logic        more;
        logic [7:0]  b2;
        logic [63:0] data;
    } emit_t;

    // Low tag nibble plus one, modulo ten.
    function automatic logic [3:0] next_count(input logic [3:0] low);
        logic [4:0] n;
        n = {1'b0, low} + 5'd1;
        if (n >= TAG_MOD) begin
            n = n - TAG_MOD;
        end
        return n[3:0];
    endfunction

    // Stored byte to display byte: first row to the MSB, pixels inverted.
    function automatic logic [7:0] cell_byte(input logic [7:0] d);
        logic [7:0] v;
        for (int i = 0; i < 8; i++) begin
            v[7-i] = ~d[i];
        end
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/lcdcf_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lcdcf_ram #(
    parameter int WIDTH = lcdcf_pkg::FB_WIDTH,
    parameter int DEPTH = lcdcf_pkg::FB_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/lcdcf_pkt.sv */
// Command register file, packet formatting and result output register.
`default_nettype none
module lcdcf_pkt (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lcdcf_pkg::emit_t    req,
    output logic                     out_free,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [95:0]              m_tdata,   // read_value, byte_two, byte_three,
                                                // payload, tag_byte, more_dirty, zero pad
    output logic                     m_tuser,   // kind
    output logic                     m_tlast
);

    logic [7:0]  b2_reg, b2_next;
    logic [7:0]  b3_reg, b3_next;
    logic [63:0] pay_reg, pay_next;
    logic [7:0]  tag_reg, tag_next;
    logic        valid_reg, valid_next;
    logic        kind_reg, kind_next;
    logic        rbit_reg, rbit_next;
    logic        last_reg, last_next;
    logic        more_reg, more_next;
    logic [3:0]  cnt;

    assign out_free = !valid_reg || m_tready;
    assign cnt      = lcdcf_pkg::next_count(tag_reg[3:0]);

    always_comb begin
        b2_next    = b2_reg;
        b3_next    = b3_reg;
        pay_next   = pay_reg;
        tag_next   = tag_reg;
        valid_next = valid_reg && !m_tready;
        kind_next  = kind_reg;
        rbit_next  = rbit_reg;
        last_next  = last_reg;
        more_next  = more_reg;
        if (req.go) begin
            valid_next = 1'b1;
            kind_next  = lcdcf_pkg::KIND_CMD;
            rbit_next  = 1'b0;
            last_next  = 1'b1;
            more_next  = 1'b0;
            unique case (req.op)
                lcdcf_pkg::OP_READ: begin
                    kind_next = lcdcf_pkg::KIND_READ;
                    rbit_next = req.rbit;
                end
                lcdcf_pkg::OP_CELL1: begin
                    b3_next   = b3_reg ^ 8'h01;
                    tag_next  = {lcdcf_pkg::TAG_CELL1, cnt};
                    b2_next   = req.b2;
                    pay_next  = req.data;
                    last_next = 1'b0;
                    more_next = req.more;
                end
                lcdcf_pkg::OP_CELL2: begin
                    b3_next   = b3_reg ^ 8'h01;
                    tag_next  = {lcdcf_pkg::TAG_CELL2, cnt};
                    b2_next   = req.b2;
                    pay_next  = req.data;
                    more_next = req.more;
                end
                lcdcf_pkg::OP_BL: begin
                    b3_next  = b3_reg ^ 8'h01;
                    tag_next = {lcdcf_pkg::TAG_BL, cnt};
                    b2_next  = req.on ? lcdcf_pkg::BL_ON : lcdcf_pkg::BL_OFF;
                    pay_next = '0;
                end
                lcdcf_pkg::OP_INIT: begin
                    b2_next  = lcdcf_pkg::INIT_B2;
                    b3_next  = lcdcf_pkg::INIT_B3;
                    tag_next = lcdcf_pkg::INIT_TAG;
                    pay_next = {lcdcf_pkg::INIT_PAY, pay_reg[23:0]};
                end
                default: begin
                    valid_next = valid_reg && !m_tready;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_reg    <= '0;
            b3_reg    <= '0;
            pay_reg   <= '0;
            tag_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            b2_reg    <= b2_next;
            b3_reg    <= b3_next;
            pay_reg   <= pay_next;
            tag_reg   <= tag_next;
            valid_reg <= valid_next;
        end
        kind_reg <= kind_next;
        rbit_reg <= rbit_next;
        last_reg <= last_next;
        more_reg <= more_next;
    end

    // Read results show zeros in all command fields.
    always_comb begin
        m_tvalid = valid_reg;
        m_tuser  = kind_reg;
        m_tlast  = last_reg;
        if (kind_reg == lcdcf_pkg::KIND_READ) begin
            m_tdata = {95'd0, rbit_reg};
        end else begin
            m_tdata = {6'd0, more_reg, tag_reg, pay_reg, b3_reg, b2_reg, 1'b0};
        end
    end

endmodule
`default_nettype wire

/* rtl/core/lcdcf_seq.sv */
// Item sequencer: clearing pass, pixel read-modify-write, dirty scan and cell fetch.
`default_nettype none
module lcdcf_seq (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,
    input  wire logic [2:0]                      s_tuser,
    output logic                                 fb_we,
    output logic [lcdcf_pkg::FB_AW-1:0]          fb_waddr,
    output logic [lcdcf_pkg::FB_WIDTH-1:0]       fb_wdata,
    output logic [lcdcf_pkg::FB_AW-1:0]          fb_raddr,
    input  wire logic [lcdcf_pkg::FB_WIDTH-1:0]  fb_rdata,
    output logic                                 dm_we,
    output logic [lcdcf_pkg::DM_AW-1:0]          dm_waddr,
    output logic [lcdcf_pkg::DM_WIDTH-1:0]       dm_wdata,
    output logic [lcdcf_pkg::DM_AW-1:0]          dm_raddr,
    input  wire logic [lcdcf_pkg::DM_WIDTH-1:0]  dm_rdata,
    input  wire logic                            out_free,
    output lcdcf_pkg::emit_t                     req
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_PIX   = 4'd2;
    localparam logic [3:0] ST_SCAN  = 4'd3;
    localparam logic [3:0] ST_DCLR  = 4'd4;
    localparam logic [3:0] ST_FETCH = 4'd5;
    localparam logic [3:0] ST_PK1   = 4'd6;
    localparam logic [3:0] ST_PK2   = 4'd7;
    localparam logic [3:0] ST_INIT  = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    localparam logic [lcdcf_pkg::FB_AW-1:0] FB_LAST =
        lcdcf_pkg::FB_AW'(lcdcf_pkg::FB_DEPTH - 1);

    logic [3:0]   state_reg, state_next;
    logic [lcdcf_pkg::FB_AW-1:0] addr_reg, addr_next;
    logic [2:0]   act_reg, act_next;
    logic [6:0]   x_reg, x_next;
    logic [6:0]   y_reg, y_next;
    logic         val_reg, val_next;
    logic         on_reg, on_next;
    logic         inr_reg, inr_next;
    logic [3:0]   col_reg, col_next;
    logic         found_reg, found_next;
    logic [3:0]   fcol_reg, fcol_next;
    logic [1:0]   frow_reg, frow_next;
    logic [3:0]   fword_reg, fword_next;
    logic         more_reg, more_next;
    logic [3:0]   bcnt_reg, bcnt_next;
    logic [127:0] cell_reg, cell_next;
    logic [7:0]   sum_reg, sum_next;

    logic [6:0]   in_x, in_y;
    logic [2:0]   in_act;
    logic         in_inr;
    logic         accept;
    logic [7:0]   cbyte;
    logic [7:0]   pos;
    logic [1:0]   low_row;
    logic [3:0]   bnext;

    assign in_act = s_tuser;
    assign in_x   = s_tdata[6:0];
    assign in_y   = s_tdata[13:7];
    assign in_inr = (in_x <= lcdcf_pkg::X_MAX) && !in_y[6];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cbyte    = lcdcf_pkg::cell_byte(fb_rdata);
    assign pos      = {~frow_reg, 2'b00, fcol_reg};
    assign bnext    = bcnt_reg + 4'd1;

    always_comb begin
        priority if (dm_rdata[0]) begin
            low_row = 2'd0;
        end else if (dm_rdata[1]) begin
            low_row = 2'd1;
        end else if (dm_rdata[2]) begin
            low_row = 2'd2;
        end else begin
            low_row = 2'd3;
        end
    end

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        act_next   = act_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        val_next   = val_reg;
        on_next    = on_reg;
        inr_next   = inr_reg;
        col_next   = col_reg;
        found_next = found_reg;
        fcol_next  = fcol_reg;
        frow_next  = frow_reg;
        fword_next = fword_reg;
        more_next  = more_reg;
        bcnt_next  = bcnt_reg;
        cell_next  = cell_reg;
        sum_next   = sum_reg;

        fb_we    = 1'b0;
        fb_waddr = {x_reg, y_reg[5:3]};
        fb_wdata = fb_rdata;
        fb_raddr = {x_reg, y_reg[5:3]};
        dm_we    = 1'b0;
        dm_waddr = x_reg[6:3];
        dm_wdata = dm_rdata | (4'b0001 << y_reg[5:4]);
        dm_raddr = x_reg[6:3];

        req      = '0;
        req.op   = act_reg == lcdcf_pkg::ACT_INIT ? lcdcf_pkg::OP_INIT : lcdcf_pkg::OP_BL;
        req.on   = on_reg;
        req.more = more_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                fb_we    = 1'b1;
                fb_waddr = addr_reg;
                fb_wdata = '0;
                dm_we    = addr_reg <= lcdcf_pkg::FB_AW'(lcdcf_pkg::DM_LAST);
                dm_waddr = addr_reg[lcdcf_pkg::DM_AW-1:0];
                dm_wdata = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == FB_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                fb_raddr = {in_x, in_y[5:3]};
                dm_raddr = (in_act == lcdcf_pkg::ACT_REDRAW) ? '0 : in_x[6:3];
                if (accept) begin
                    act_next   = in_act;
                    x_next     = in_x;
                    y_next     = in_y;
                    val_next   = s_tdata[14];
                    on_next    = s_tdata[15];
                    inr_next   = in_inr;
                    col_next   = '0;
                    found_next = 1'b0;
                    more_next  = 1'b0;
                    addr_next  = '0;
                    unique case (in_act)
                        lcdcf_pkg::ACT_WRITE:     state_next = in_inr ? ST_PIX : ST_IDLE;
                        lcdcf_pkg::ACT_READ:      state_next = ST_PIX;
                        lcdcf_pkg::ACT_REDRAW:    state_next = ST_SCAN;
                        lcdcf_pkg::ACT_BACKLIGHT: state_next = ST_EMIT;
                        lcdcf_pkg::ACT_INIT:      state_next = ST_INIT;
                        default:                  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX: begin
                if (act_reg == lcdcf_pkg::ACT_WRITE) begin
                    // Store and mark dirty only when the bit really changes.
                    if (fb_rdata[y_reg[2:0]] != val_reg) begin
                        fb_we = 1'b1;
                        fb_wdata[y_reg[2:0]] = val_reg;
                        dm_we = 1'b1;
                    end
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    req.go     = 1'b1;
                    req.op     = lcdcf_pkg::OP_READ;
                    req.rbit   = inr_reg && fb_rdata[y_reg[2:0]];
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // dm_rdata holds the word of column col_reg.
                dm_raddr = col_reg + 4'd1;
                if (dm_rdata != '0) begin
                    if (!found_reg) begin
                        found_next = 1'b1;
                        fcol_next  = col_reg;
                        frow_next  = low_row;
                        fword_next = dm_rdata & (dm_rdata - 4'd1);
                        more_next  = (dm_rdata & (dm_rdata - 4'd1)) != '0;
                    end else begin
                        more_next = 1'b1;
                    end
                end
                col_next = col_reg + 4'd1;
                if (col_reg == lcdcf_pkg::DM_LAST) begin
                    state_next = (found_reg || dm_rdata != '0) ? ST_DCLR : ST_IDLE;
                end
            end
            ST_DCLR: begin
                dm_we     = 1'b1;
                dm_waddr  = fcol_reg;
                dm_wdata  = fword_reg;
                fb_raddr  = {fcol_reg, 3'd0, frow_reg, 1'b1};
                bcnt_next = '0;
                sum_next  = pos;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                // Even bytes take the lower half of the cell column, odd the upper.
                fb_raddr  = {fcol_reg, bnext[3:1], frow_reg, ~bnext[0]};
                cell_next = {cell_reg[119:0], cbyte};
                sum_next  = sum_reg ^ cbyte;
                bcnt_next = bnext;
                if (bcnt_reg == 4'd15) begin
                    state_next = ST_PK1;
                end
            end
            ST_PK1: begin
                if (out_free) begin
                    req.go     = 1'b1;
                    req.op     = lcdcf_pkg::OP_CELL1;
                    req.b2     = pos;
                    req.data   = cell_reg[127:64];
                    state_next = ST_PK2;
                end
            end
            ST_PK2: begin
                if (out_free) begin
                    req.go     = 1'b1;
                    req.op     = lcdcf_pkg::OP_CELL2;
                    req.b2     = cell_reg[63:56];
                    req.data   = {cell_reg[55:0], sum_reg};
                    state_next = ST_IDLE;
                end
            end
            ST_INIT: begin
                dm_we     = 1'b1;
                dm_waddr  = addr_reg[lcdcf_pkg::DM_AW-1:0];
                dm_wdata  = '1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg[lcdcf_pkg::DM_AW-1:0] == lcdcf_pkg::DM_LAST) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    req.go     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
        act_reg   <= act_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        val_reg   <= val_next;
        on_reg    <= on_next;
        inr_reg   <= inr_next;
        col_reg   <= col_next;
        found_reg <= found_next;
        fcol_reg  <= fcol_next;
        frow_reg  <= frow_next;
        fword_reg <= fword_next;
        more_reg  <= more_next;
        bcnt_reg  <= bcnt_next;
        cell_reg  <= cell_next;
        sum_reg   <= sum_next;
    end

endmodule
`default_nettype wire

/* rtl/core/lcd_cell_framebuffer_packetizer.sv */
// Top level of the 96x64 cell frame buffer packetizer.
//
// Input stream (s_*): one request per item, action in s_tuser, pixel
// position and values in s_tdata. Result stream (m_*): pixel read data or
// display command packets, kind in m_tuser, m_tlast on the final result
// of a request.
// After reset a clearing pass zeroes the pixel RAM and the dirty map;
// s_tready stays low during it.
// One request is worked on at a time; the steps of each action:
//   pixel write  read, then write back if the bit changed
//   pixel read   read, then the result goes to the output register
//   backlight    one packet; init a 12-entry dirty map sweep, then one packet
//   redraw       a 12-word dirty map scan, a state that clears the cell
//                bit, 16 reads of the byte-wide pixel RAM, then two packets;
//                only the scan when nothing is dirty.
// The byte-wide pixel RAM port and the per-column dirty scan set the length
// of a redraw. Results sit in an output register, so the next request is
// taken while a result waits; a stalled m_tready holds the result, and the
// next request with a result of its own waits for the register, so intake
// stops behind it. Pixel writes go on while a result waits.
`default_nettype none
module lcd_cell_framebuffer_packetizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // pos_x, pos_y, pixel_value, backlight_on
    input  wire logic [2:0]  s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // read_value, byte_two, byte_three, payload,
                                        // tag_byte, more_dirty, zero pad
    output logic             m_tuser,   // kind
    output logic             m_tlast
);

    logic                                fb_we;
    logic [lcdcf_pkg::FB_AW-1:0]         fb_waddr, fb_raddr;
    logic [lcdcf_pkg::FB_WIDTH-1:0]      fb_wdata, fb_rdata;
    logic                                dm_we;
    logic [lcdcf_pkg::DM_AW-1:0]         dm_waddr, dm_raddr;
    logic [lcdcf_pkg::DM_WIDTH-1:0]      dm_wdata, dm_rdata;
    logic                                out_free;
    lcdcf_pkg::emit_t                    req;

    lcdcf_ram #(
        .WIDTH (lcdcf_pkg::FB_WIDTH),
        .DEPTH (lcdcf_pkg::FB_DEPTH)
    ) u_fb_ram (
        .aclk  (aclk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    lcdcf_ram #(
        .WIDTH (lcdcf_pkg::DM_WIDTH),
        .DEPTH (lcdcf_pkg::DM_DEPTH)
    ) u_dm_ram (
        .aclk  (aclk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (dm_raddr),
        .rdata (dm_rdata)
    );

    lcdcf_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .fb_we    (fb_we),
        .fb_waddr (fb_waddr),
        .fb_wdata (fb_wdata),
        .fb_raddr (fb_raddr),
        .fb_rdata (fb_rdata),
        .dm_we    (dm_we),
        .dm_waddr (dm_waddr),
        .dm_wdata (dm_wdata),
        .dm_raddr (dm_raddr),
        .dm_rdata (dm_rdata),
        .out_free (out_free),
        .req      (req)
    );

    lcdcf_pkt u_pkt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
